// File: hdl/selective_repeat_receiver_core_defines.svh
// ----------------------------------------------------------------------------
// selective repeat receiver assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SRR_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define SRR_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: hdl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// shared widths, codes and controller/datapath interface types of the
// selective repeat receiver
// ----------------------------------------------------------------------------
package srr_pkg;

    // field widths
    localparam int SEQ_W      = 16;
    localparam int CFG_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = ((SEQ_W + STATUS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - SEQ_W - STATUS_W;

    // defaults
    localparam int MAX_WINDOW_DEF = 64;
    localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(8);

    // per-frame outcome
    typedef enum logic [STATUS_W-1:0] {
        ST_DROPPED  = 2'd0,
        ST_STORED   = 2'd1,
        ST_ADVANCED = 2'd2
    } t_frame_status;

    // controller to datapath commands
    typedef struct packed {
        logic clr_wr;        // clear one map slot during the reset sweep
        logic load_in;       // capture an arriving word
        logic mod_step;      // compute the frame's slot
        logic rd_seq;        // read the map at the frame's slot
        logic rd_base;       // read the map at the base slot
        logic latch_status;  // hold the verdict for the result
        logic mark;          // set the frame's slot
        logic advance;       // move the base past the expected frame
        logic clear_adv;     // clear the base slot and move the base on
        logic out_load;      // fill the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic          clr_last;
        logic          map_bit;
        logic          out_free;
        t_frame_status verdict;
    } t_dp_sts;

endpackage

// File: hdl/selective_repeat_receiver_core.sv
// a dropped or stored frame passes the slot, map read and decide steps before its result is loaded
// an in-order frame also runs the scan, which reads and clears each further marked slot
// a new frame is taken only once the last result has been loaded into the output
// a result held by the output stalls the next result's hand-off until it is taken
// reset: synchronous, active low; afterwards the map sweep clears all MAX_WINDOW slots
// during that sweep no frame is taken; window size returns to 8
// ----------------------------------------------------------------------------
// selective_repeat_receiver_core
// receiver side of a sliding-window transfer with a circular received map and
// one cumulative acknowledgement per arriving frame
// ----------------------------------------------------------------------------
module selective_repeat_receiver_core #(
    parameter int MAX_WINDOW = srr_pkg::MAX_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // frame stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // bits [15:0] frame_seq
    input  logic [srr_pkg::SEQ_W-1:0]       s_axis_tdata,
    // acknowledgement stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // bits [15:0] ack_seq, [17:16] frame_status, [23:18] zero
    output logic [srr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // bit [0] ack_valid
    output logic                            m_axis_tuser,
    // window size register
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srr_pkg::CFG_W-1:0]       i_cfg_data
);
    import srr_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer
    srr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    // datapath
    srr_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_seq   (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: hdl/srr_ctrl.sv
// ----------------------------------------------------------------------------
// srr_ctrl
// sequencer of the selective repeat receiver: reset sweep of the map, slot
// computation, map lookup, window advance scan and result hand-off
// ----------------------------------------------------------------------------
`include "selective_repeat_receiver_core_defines.svh"

module srr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  srr_pkg::t_dp_sts  i_sts,
    output srr_pkg::t_dp_cmd  o_cmd
);
    import srr_pkg::*;

    typedef enum logic [7:0] {
        S_CLR      = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_MOD      = 8'b0000_0100,
        S_RD       = 8'b0000_1000,
        S_DEC      = 8'b0001_0000,
        S_SCAN_RD  = 8'b0010_0000,
        S_SCAN_CHK = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                o_cmd.rd_seq = 1'b1;
                n_state      = S_DEC;
            end
            S_DEC: begin
                o_cmd.latch_status = 1'b1;
                unique case (i_sts.verdict)
                    ST_STORED: begin
                        o_cmd.mark = 1'b1;
                        n_state    = S_OUT;
                    end
                    ST_ADVANCED: begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_SCAN_RD;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_SCAN_RD: begin
                o_cmd.rd_base = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.map_bit) begin
                    o_cmd.clear_adv = 1'b1;
                    n_state         = S_SCAN_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // checks
    `SRR_ASSERT_NEXT(a_accept_starts_mod, w_accept, r_state == S_MOD, "word accepted but slot unit not started")
    `SRR_ASSERT_SAME(a_scan_after_read, r_state == S_SCAN_CHK, $past(r_state) == S_SCAN_RD, "scan check without a map read")
    `SRR_ASSERT_NEXT(a_out_returns_idle, o_cmd.out_load, r_state == S_IDLE, "result loaded but not back to idle")

endmodule

// File: hdl/srr_dp.sv
// ----------------------------------------------------------------------------
// srr_dp
// datapath of the selective repeat receiver: window register, slot
// computation, received map memory, window base and the output register
// ----------------------------------------------------------------------------
`include "selective_repeat_receiver_core_defines.svh"

module srr_dp #(
    parameter int MAX_WINDOW = srr_pkg::MAX_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // arriving frame number
    input  logic [srr_pkg::SEQ_W-1:0]       i_frame_seq,
    // window size register
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srr_pkg::CFG_W-1:0]       i_cfg_data,
    // controller link
    input  srr_pkg::t_dp_cmd                i_cmd,
    output srr_pkg::t_dp_sts                o_sts,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // bits [15:0] ack_seq, [17:16] frame_status, [23:18] zero
    output logic [srr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // bit [0] ack_valid
    output logic                            m_axis_tuser
);
    import srr_pkg::*;

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int REM_W  = SLOT_W + 1;
    localparam int WIN_W  = ($clog2(MAX_WINDOW + 1) > CFG_W) ? $clog2(MAX_WINDOW + 1) : CFG_W;
    localparam logic [REM_W-1:0]  W_REM     = REM_W'(MAX_WINDOW);
    localparam logic [WIN_W-1:0]  W_WIN     = WIN_W'(MAX_WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_WINDOW - 1);

    // registers
    logic [CFG_W-1:0]     r_win;
    logic [SEQ_W-1:0]     r_frame_seq;
    logic [SLOT_W-1:0]    r_rem;
    logic [SEQ_W-1:0]     r_next;
    logic [SLOT_W-1:0]    r_base_slot;
    logic                 r_any;
    logic [SLOT_W-1:0]    r_clr_idx;
    logic                 r_map [MAX_WINDOW];
    logic                 r_rd_bit;
    t_frame_status        r_status;
    logic                 r_out_valid;
    logic                 r_out_ack_valid;
    logic [SEQ_W-1:0]     r_out_ack_seq;
    t_frame_status        r_out_status;

    // next values and combinational terms
    logic [SLOT_W-1:0]    n_rem;
    logic                 w_wrapped;
    logic [REM_W-1:0]     w_slot_sum;
    logic [REM_W-1:0]     w_slot_red;
    logic [SLOT_W-1:0]    n_base_slot;
    logic [WIN_W-1:0]     w_win_eff;
    logic [SEQ_W-1:0]     w_offset;
    logic                 w_in_win;
    t_frame_status        w_verdict;
    logic                 w_wr_en;
    logic [SLOT_W-1:0]    w_wr_addr;
    logic                 w_rd_en;
    logic [SLOT_W-1:0]    w_rd_addr;
    logic                 w_step_base;
    logic                 w_out_free;

    assign o_cfg_ready = 1'b1;

    // window size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (i_cfg_valid) begin
            r_win <= i_cfg_data;
        end
    end

    // frame slot from the base slot, only meaningful inside the map span
    // below the base the number has wrapped past zero and is its own slot
    assign w_wrapped  = r_frame_seq < r_next;
    assign w_slot_sum = REM_W'(r_base_slot) + REM_W'(w_offset[SLOT_W-1:0]);
    assign w_slot_red = (w_slot_sum >= W_REM) ? (w_slot_sum - W_REM) : w_slot_sum;
    assign n_rem      = w_wrapped ? r_frame_seq[SLOT_W-1:0] : w_slot_red[SLOT_W-1:0];

    // frame capture and slot register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_frame_seq <= i_frame_seq;
        end
        if (i_cmd.mod_step) begin
            r_rem <= n_rem;
        end
    end

    // in-window test and verdict against the map bit just read
    assign w_win_eff = (WIN_W'(r_win) > W_WIN) ? W_WIN : WIN_W'(r_win);
    assign w_offset  = r_frame_seq - r_next;
    assign w_in_win  = w_offset < SEQ_W'(w_win_eff);

    always_comb begin
        priority if (!w_in_win) begin
            w_verdict = ST_DROPPED;
        end else if (r_rd_bit) begin
            w_verdict = ST_DROPPED;
        end else if (w_offset != '0) begin
            w_verdict = ST_STORED;
        end else begin
            w_verdict = ST_ADVANCED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_status) begin
            r_status <= w_verdict;
        end
    end

    // window base and its slot, slot tracked alongside the number
    assign w_step_base = i_cmd.advance || i_cmd.clear_adv;
    assign n_base_slot = (r_next == '1 || r_base_slot == LAST_SLOT) ? '0
                       : r_base_slot + SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next      <= '0;
            r_base_slot <= '0;
            r_any       <= 1'b0;
        end else begin
            if (w_step_base) begin
                r_next      <= r_next + SEQ_W'(1);
                r_base_slot <= n_base_slot;
            end
            if (i_cmd.advance) begin
                r_any <= 1'b1;
            end
        end
    end

    // reset sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_idx <= r_clr_idx + SLOT_W'(1);
        end
    end

    // received map memory, one write and one registered read port
    assign w_wr_en   = i_cmd.clr_wr || i_cmd.mark || i_cmd.clear_adv;
    assign w_wr_addr = i_cmd.clr_wr ? r_clr_idx : (i_cmd.mark ? r_rem : r_base_slot);
    assign w_rd_en   = i_cmd.rd_seq || i_cmd.rd_base;
    assign w_rd_addr = i_cmd.rd_seq ? r_rem : r_base_slot;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_map[w_wr_addr] <= i_cmd.mark;
        end
        if (w_rd_en) begin
            r_rd_bit <= r_map[w_rd_addr];
        end
    end

    // output register
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ack_valid <= r_any;
            r_out_ack_seq   <= r_any ? (r_next - SEQ_W'(1)) : '0;
            r_out_status    <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_status, r_out_ack_seq};
    assign m_axis_tuser  = r_out_ack_valid;

    // status to the controller
    assign o_sts.clr_last = (r_clr_idx == LAST_SLOT);
    assign o_sts.map_bit  = r_rd_bit;
    assign o_sts.out_free = w_out_free;
    assign o_sts.verdict  = w_verdict;

    // checks
    `SRR_ASSERT_SAME(a_one_map_writer, 1'b1, $onehot0({i_cmd.clr_wr, i_cmd.mark, i_cmd.clear_adv}), "conflicting map writes")
    `SRR_ASSERT_SAME(a_clear_only_marked, i_cmd.clear_adv, r_rd_bit, "scan clears a slot that was not marked")
    `SRR_ASSERT_NEXT(a_advance_sets_any, i_cmd.advance, r_any && r_next == $past(r_next) + SEQ_W'(1), "advance did not move the base")

endmodule
